[rtl/lppd_pkg.sv]
// Package with the types, codes and constants shared by the packet deframer files.
`default_nettype none
package lppd_pkg;

  // Header layout, in bytes.
  localparam int unsigned HDR_BYTES = 40;
  localparam logic [31:0] HDR_LAST = 32'(HDR_BYTES - 1);
  localparam logic [31:0] CMD_OFS = 32'd2;
  localparam logic [31:0] LEN_OFS = 32'd4;

  // Body limit after reset.
  localparam logic [31:0] LIMIT_AT_RESET = 32'd1024000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LIMIT = 1'd1;

  // Framing phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ERROR = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  // Byte status codes.
  localparam logic [1:0] ST_PART = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_LENERR = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_end;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_status;
    logic [15:0] command_code;
    logic [31:0] body_bytes;
  } res_t;

  typedef struct packed {
    logic        link_mode;
    logic [31:0] body_limit;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/lppd_byte_if.sv]
// Interface for the received byte channel.
`default_nettype none
interface lppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       datagram_end;

  modport source (output valid, output data_byte, output datagram_end, input ready);
  modport sink (input valid, input data_byte, input datagram_end, output ready);
endinterface
`default_nettype wire

[rtl/lppd_res_if.sv]
// Interface for the tagged result byte channel.
`default_nettype none
interface lppd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_status;
  logic [15:0] command_code;
  logic [31:0] body_bytes;

  modport source (output valid, output out_byte, output byte_status,
                  output command_code, output body_bytes, input ready);
  modport sink (input valid, input out_byte, input byte_status,
                input command_code, input body_bytes, output ready);
endinterface
`default_nettype wire

[rtl/lppd_cfg_if.sv]
// Interface for the configuration write channel.
`default_nettype none
interface lppd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lppd_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/lppd_cfg_regs.sv]
// Configuration registers of the packet deframer.
`default_nettype none
module lppd_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lppd_cfg_if.sink      cfg_ch,
  output lppd_pkg::cfg_t cfg
);

  logic        link_mode_r;
  logic [31:0] body_limit_r;
  logic        wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r  <= 1'b0;
      body_limit_r <= lppd_pkg::LIMIT_AT_RESET;
    end else if (wr) begin
      case (cfg_ch.index)
        lppd_pkg::REG_LINK_MODE: link_mode_r <= cfg_ch.data[0];
        lppd_pkg::REG_BODY_LIMIT: body_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.link_mode = link_mode_r;
  assign cfg.body_limit = body_limit_r;

endmodule
`default_nettype wire

[rtl/lppd_framer.sv]
// Framing state and the per-byte step that tags one byte.
`default_nettype none
module lppd_framer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire lppd_pkg::cfg_t  cfg,
  input  wire lppd_pkg::item_t item,
  output lppd_pkg::res_t       res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [31:0] len_r, len_nxt;
  logic        dgram;
  logic        at_end;
  logic        body_last;

  assign dgram = cfg.link_mode;
  assign at_end = item.datagram_end;
  assign body_last = ({1'b0, pos_r} + 33'd1) >= {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt = pos_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    res.out_byte = item.data_byte;
    res.byte_status = lppd_pkg::ST_PART;
    res.command_code = '0;
    res.body_bytes = '0;

    case (phase_r)
      lppd_pkg::PH_ERROR: begin
        res.byte_status = lppd_pkg::ST_LENERR;
      end
      lppd_pkg::PH_DISCARD: begin
        res.byte_status = lppd_pkg::ST_DROP;
        if (at_end) begin
          phase_nxt = lppd_pkg::PH_HEADER;
          pos_nxt = '0;
        end
      end
      lppd_pkg::PH_HEADER: begin
        // Little-endian capture of the command id and body length.
        if (pos_r == lppd_pkg::CMD_OFS) begin
          cmd_nxt[7:0] = item.data_byte;
        end else if (pos_r == lppd_pkg::CMD_OFS + 32'd1) begin
          cmd_nxt[15:8] = item.data_byte;
        end else if (pos_r[31:2] == lppd_pkg::LEN_OFS[31:2]) begin
          len_nxt[8*pos_r[1:0] +: 8] = item.data_byte;
        end

        if (pos_r >= lppd_pkg::HDR_LAST) begin
          pos_nxt = '0;
          res.command_code = cmd_r;
          res.body_bytes = len_r;
          if (len_r >= cfg.body_limit) begin
            res.byte_status = lppd_pkg::ST_LENERR;
            if (!dgram) begin
              phase_nxt = lppd_pkg::PH_ERROR;
            end else begin
              phase_nxt = at_end ? lppd_pkg::PH_HEADER : lppd_pkg::PH_DISCARD;
            end
          end else if (len_r == '0) begin
            res.byte_status = lppd_pkg::ST_DONE;
            phase_nxt = (dgram && !at_end) ? lppd_pkg::PH_DISCARD : lppd_pkg::PH_HEADER;
          end else if (dgram && at_end) begin
            res.byte_status = lppd_pkg::ST_DROP;
            phase_nxt = lppd_pkg::PH_HEADER;
          end else begin
            phase_nxt = lppd_pkg::PH_BODY;
          end
        end else begin
          pos_nxt = pos_r + 32'd1;
          if (dgram && at_end) begin
            res.byte_status = lppd_pkg::ST_DROP;
            pos_nxt = '0;
          end
        end
      end
      default: begin
        res.command_code = cmd_r;
        res.body_bytes = len_r;
        if (body_last) begin
          res.byte_status = lppd_pkg::ST_DONE;
          pos_nxt = '0;
          phase_nxt = (dgram && !at_end) ? lppd_pkg::PH_DISCARD : lppd_pkg::PH_HEADER;
        end else begin
          pos_nxt = pos_r + 32'd1;
          if (dgram && at_end) begin
            res.byte_status = lppd_pkg::ST_DROP;
            pos_nxt = '0;
            phase_nxt = lppd_pkg::PH_HEADER;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lppd_pkg::PH_HEADER;
      pos_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/length_prefixed_packet_deframer.sv]
// Top level of the length-prefixed packet deframer.
//
//   Channel   Direction  Carries
//   in_ch     sink       data_byte, datagram_end
//   out_ch    source     out_byte, byte_status, command_code, body_bytes
//   cfg_ch    sink       index, data (0 link_mode, 1 body_limit)
//
// Every received byte yields exactly one tagged result byte. A byte is
// registered at the input, tagged by the framer as it leaves the input
// register and written to the output register, which offers the result.
// One byte per cycle is sustained while out_ch is ready; the only loop is
// the framing state update, which is a single short step per byte.
// Reset (rst_n low, synchronous) empties both registers, returns the framer
// to the header phase and loads the register defaults.
// A stall on out_ch holds the result; the input register still takes one
// more byte, after which in_ch.ready follows out_ch.ready.
`default_nettype none
module length_prefixed_packet_deframer (
  input wire logic  clk,
  input wire logic  rst_n,
  lppd_byte_if.sink in_ch,
  lppd_res_if.source out_ch,
  lppd_cfg_if.sink  cfg_ch
);

  lppd_pkg::cfg_t  cfg;
  lppd_pkg::item_t in_item;
  lppd_pkg::item_t s1_item_r;
  lppd_pkg::res_t  res;
  lppd_pkg::res_t  out_res_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            in_xfer;
  logic            step;

  lppd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The input register moves on when the output register is empty or
  // its result is being transferred out in this cycle.
  assign step = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || step;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.datagram_end = in_ch.datagram_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
  end

  // The framer state advances only when a byte really leaves the input
  // register, so stalls never repeat or skip a byte.
  lppd_framer u_framer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_res_r.out_byte;
  assign out_ch.byte_status = out_res_r.byte_status;
  assign out_ch.command_code = out_res_r.command_code;
  assign out_ch.body_bytes = out_res_r.body_bytes;

endmodule
`default_nettype wire

[rtl/lppd_checker.sv]
// Port-level checks for the packet deframer and the bind that attaches them.
`default_nettype none
module lppd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic [1:0]  byte_status,
  input wire logic [15:0] command_code,
  input wire logic [31:0] body_bytes
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A transfer in, followed by a free output side, gives a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready ##1 out_ready) |=> out_valid)
    else $error("accepted byte produced no result");

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(byte_status)
      && $stable(command_code) && $stable(body_bytes)))
    else $error("result payload changed while stalled");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .byte_status  (out_ch.byte_status),
  .command_code (out_ch.command_code),
  .body_bytes   (out_ch.body_bytes)
);
`default_nettype wire
